[hdl/a2e_pkg.sv]
`default_nettype none

package a2e_pkg;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_NO_CR = 2'd1,
        ST_NO_LF = 2'd2
    } status_t;

    localparam logic [7:0] XLAT_ROM [0:255] = '{
        8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,
        8'h16,8'h05,8'h15,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
        8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,
        8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
        8'h40,8'h4F,8'h7F,8'h7B,8'hE0,8'h6C,8'h50,8'h7D,
        8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
        8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,
        8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
        8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,
        8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
        8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,
        8'hE7,8'hE8,8'hE9,8'h4A,8'h5B,8'h5A,8'h5F,8'h6D,
        8'h79,8'h57,8'h59,8'h62,8'h63,8'h64,8'h65,8'h66,
        8'h67,8'h68,8'h69,8'h70,8'h71,8'h72,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h80,8'h8B,8'h9B,8'h9C,
        8'hA0,8'hAB,8'hB0,8'hC0,8'h6A,8'hD0,8'hA1,8'h07,
        8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h06,8'h17,
        8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
        8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,
        8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hE1,
        8'hB1,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
        8'h48,8'h49,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,
        8'h58,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8A,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,
        8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,
        8'h99,8'h9A,8'h9D,8'h9E,8'h9F,8'hA2,8'hA3,8'hA4,
        8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hAC,8'hAD,
        8'hAE,8'hAF,8'hBA,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,
        8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,
        8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hDA,8'hDB,
        8'hDC,8'hDD,8'hDE,8'hDF,8'hEA,8'hEB,8'hEC,8'hED,
        8'hEE,8'hEF,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
    };

endpackage

`default_nettype wire

[hdl/ascii_to_ebcdic_record_deframer_top.sv]
// ascii to ebcdic translator with fixed-length record deframing
//
// input channel: in_valid / in_stall / in_byte, one ascii byte per transfer.
// output channel: out_valid / out_stall / out_byte / status, zero or one
// result per input byte. status 0 is a translated byte, 1 means the byte at
// the cr slot was not cr, 2 means the byte at the lf slot was not lf; an
// error result carries out_byte 0 and halts the block until reset, after
// which input bytes are still taken but dropped.
// record_length_write / record_length set the data bytes per record (0 turns
// framing off) and restart framing at a record boundary; write only when idle.
// cr and lf bytes at the end of each record are checked and dropped.
//
// path: input transfer into the input register, then rom lookup and record
// counter into the result register, which drives out_valid.
// throughput: one byte per cycle while out_stall lets the result drain; the
// record counter update is the single step per byte.
// reset: record length 0, position at start of record, not halted, both
// registers empty.
// when out_stall holds a result, the next byte waits in the input register
// and in_stall rises once that register is also full.
`default_nettype none

module ascii_to_ebcdic_record_deframer_top
    import a2e_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        record_length_write,
    input  wire logic [14:0] record_length,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [14:0] len_reg;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic        halted_reg;
    logic        halted_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    status_t     out_status_reg;
    status_t     out_status_next;
    logic        result_next;
    logic        advance;
    logic [15:0] len_ext;
    logic [15:0] len_plus1;

    // input register moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign len_ext   = {1'b0, len_reg};
    assign len_plus1 = len_ext + 16'd1;

    always_comb
    begin
        pos_next        = pos_reg;
        halted_next     = halted_reg;
        result_next     = 1'b0;
        out_byte_next   = XLAT_ROM[in_byte_reg];
        out_status_next = ST_DATA;
        if (halted_reg)
        begin
            result_next = 1'b0;
        end
        else if (len_reg == 15'd0)
        begin
            result_next = 1'b1;
        end
        else if (pos_reg <= len_ext)
        begin
            result_next = 1'b1;
            pos_next    = pos_reg + 16'd1;
        end
        else if (pos_reg == len_plus1)
        begin
            if (in_byte_reg != CR_BYTE)
            begin
                halted_next     = 1'b1;
                result_next     = 1'b1;
                out_byte_next   = 8'd0;
                out_status_next = ST_NO_CR;
            end
            else
            begin
                pos_next = pos_reg + 16'd1;
            end
        end
        else
        begin
            // lf slot
            if (in_byte_reg != LF_BYTE)
            begin
                halted_next     = 1'b1;
                result_next     = 1'b1;
                out_byte_next   = 8'd0;
                out_status_next = ST_NO_LF;
            end
            else
            begin
                pos_next = 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            len_reg        <= 15'd0;
            pos_reg        <= 16'd1;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DATA;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (record_length_write)
            begin
                len_reg <= record_length;
                pos_reg <= 16'd1;
            end
            else if (advance)
            begin
                pos_reg <= pos_next;
            end

            if (advance)
            begin
                halted_reg <= halted_next;
            end

            if (advance)
            begin
                out_valid_reg <= result_next;
                if (result_next)
                begin
                    out_status_reg <= out_status_next;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && result_next)
        begin
            out_byte_reg <= out_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = out_status_reg;

    // once halted, only reset brings the block back
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // a halted block never loads a new result
    assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced while halted");

    // with framing on the position stays within data, cr and lf slots
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != 15'd0) |-> (pos_reg != 16'd0 && pos_reg <= len_plus1 + 16'd1))
        else $error("record position out of range");

    // with framing off the position does not count
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == 15'd0) |-> (pos_reg == 16'd1))
        else $error("record position moved with framing off");

    // an error result shows with the halt already set and carries out_byte 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_DATA) |-> (halted_reg && out_byte_reg == 8'd0))
        else $error("error result without halt or with nonzero byte");

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
    import a2e_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1520;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned LONG_HOLD    = 40;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    // ascii to ebcdic code page, kept here independently of the design
    localparam logic [7:0] EBCDIC_OF [256] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h37, 8'h2D, 8'h2E, 8'h2F,
        8'h16, 8'h05, 8'h15, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
        8'h10, 8'h11, 8'h12, 8'h13, 8'h3C, 8'h3D, 8'h32, 8'h26,
        8'h18, 8'h19, 8'h3F, 8'h27, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
        8'h40, 8'h4F, 8'h7F, 8'h7B, 8'hE0, 8'h6C, 8'h50, 8'h7D,
        8'h4D, 8'h5D, 8'h5C, 8'h4E, 8'h6B, 8'h60, 8'h4B, 8'h61,
        8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
        8'hF8, 8'hF9, 8'h7A, 8'h5E, 8'h4C, 8'h7E, 8'h6E, 8'h6F,
        8'h7C, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
        8'hC8, 8'hC9, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6,
        8'hD7, 8'hD8, 8'hD9, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6,
        8'hE7, 8'hE8, 8'hE9, 8'h4A, 8'h5B, 8'h5A, 8'h5F, 8'h6D,
        8'h79, 8'h57, 8'h59, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
        8'h67, 8'h68, 8'h69, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h80, 8'h8B, 8'h9B, 8'h9C,
        8'hA0, 8'hAB, 8'hB0, 8'hC0, 8'h6A, 8'hD0, 8'hA1, 8'h07,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h06, 8'h17,
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h09, 8'h0A, 8'h1B,
        8'h30, 8'h31, 8'h1A, 8'h33, 8'h34, 8'h35, 8'h36, 8'h08,
        8'h38, 8'h39, 8'h3A, 8'h3B, 8'h04, 8'h14, 8'h3E, 8'hE1,
        8'hB1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
        8'h58, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
        8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
        8'h99, 8'h9A, 8'h9D, 8'h9E, 8'h9F, 8'hA2, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hAC, 8'hAD,
        8'hAE, 8'hAF, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
        8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
        8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hDA, 8'hDB,
        8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hEA, 8'hEB, 8'hEC, 8'hED,
        8'hEE, 8'hEF, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic [7:0] code;
        status_t    kind;
    } ebcdic_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        record_length_write = 1'b0;
    logic [14:0] record_length = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  status;

    logic [7:0]     ascii_pending[$];
    ebcdic_result_t ebcdic_expected[$];

    // predictor copy of the block state
    logic [14:0] frame_len = '0;
    logic [15:0] slot = 16'd1;
    logic        frozen = 1'b0;

    int unsigned items_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_granted = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          calm = 1'b0;

    ascii_to_ebcdic_record_deframer_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .record_length_write (record_length_write),
        .record_length       (record_length),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .in_byte             (in_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .out_byte            (out_byte),
        .status              (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_translation(input logic [7:0] b);
        ebcdic_result_t r;
        if (frozen)
            return;
        if (frame_len == '0)
        begin
            r.code = EBCDIC_OF[b];
            r.kind = ST_DATA;
            ebcdic_expected.push_back(r);
        end
        else if (slot <= {1'b0, frame_len})
        begin
            r.code = EBCDIC_OF[b];
            r.kind = ST_DATA;
            ebcdic_expected.push_back(r);
            slot = slot + 16'd1;
        end
        else if (slot == {1'b0, frame_len} + 16'd1)
        begin
            if (b != CR_BYTE)
            begin
                frozen = 1'b1;
                r.code = 8'h00;
                r.kind = ST_NO_CR;
                ebcdic_expected.push_back(r);
            end
            else
                slot = slot + 16'd1;
        end
        else
        begin
            if (b != LF_BYTE)
            begin
                frozen = 1'b1;
                r.code = 8'h00;
                r.kind = ST_NO_LF;
                ebcdic_expected.push_back(r);
            end
            else
                slot = 16'd1;
        end
    endfunction

    // sender: one transfer per cycle at most, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_translation(in_byte);
            if (!in_valid || !in_stall)
            begin
                next_valid = 1'b0;
                if (send_gap != 0)
                    send_gap--;
                else if (ascii_pending.size() == 0)
                    next_valid = 1'b0;
                else if (!calm && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(0, 3);
                else
                begin
                    next_valid = 1'b1;
                    in_byte <= ascii_pending.pop_front();
                end
                in_valid <= next_valid;
            end
        end
    end

    // receiver: checks each transfer, stalls in bursts and on request
    always @(posedge clk or negedge rst_n)
    begin
        ebcdic_result_t want;
        logic           next_stall;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (ebcdic_expected.size() == 0)
                begin
                    $error("unexpected result: out_byte %h status %0d", out_byte, status);
                    mismatch_count++;
                end
                else
                begin
                    want = ebcdic_expected.pop_front();
                    if (out_byte !== want.code)
                    begin
                        $error("out_byte: expected %h, got %h", want.code, out_byte);
                        mismatch_count++;
                    end
                    if (status !== want.kind)
                    begin
                        $error("status: expected %0d, got %0d", want.kind, status);
                        mismatch_count++;
                    end
                end
            end
            if (holds_granted != holds_asked)
            begin
                holds_granted++;
                hold_left = LONG_HOLD;
            end
            next_stall = 1'b0;
            if (hold_left != 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                next_stall = 1'b1;
            end
            out_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        ascii_pending.push_back(b);
        items_queued++;
    endtask

    function automatic logic [7:0] text_byte();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        // now and then a cr or lf value lands in a data slot
        if (pick == 0)
            return CR_BYTE;
        if (pick == 1)
            return LF_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_record(input int unsigned n_data, input bit with_cr,
                                input bit with_lf);
        repeat (n_data)
            queue_byte(text_byte());
        if (with_cr)
            queue_byte(CR_BYTE);
        if (with_lf)
            queue_byte(LF_BYTE);
    endtask

    task automatic wait_quiescent();
        do
            @(posedge clk);
        while (ascii_pending.size() != 0 || in_valid || ebcdic_expected.size() != 0);
        // cr and lf give no result but may still sit in the pipeline
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_record_length(input logic [14:0] len);
        wait_quiescent();
        record_length_write <= 1'b1;
        record_length       <= len;
        frame_len = len;
        slot      = 16'd1;
        @(posedge clk);
        record_length_write <= 1'b0;
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned len;
        logic [7:0]  bad;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // framing off after reset: field extremes and the framing bytes
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CR_BYTE);
        queue_byte(LF_BYTE);
        queue_byte(8'h55);
        queue_byte(8'hAA);

        // one-byte records, cr value as data, then cr and lf stripped
        set_record_length(15'd1);
        queue_byte(CR_BYTE);
        queue_byte(CR_BYTE);
        queue_byte(LF_BYTE);
        queue_byte(8'h41);
        queue_byte(CR_BYTE);
        queue_byte(LF_BYTE);

        // longest record, left open and restarted by a new length
        set_record_length(15'h7FFF);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        set_record_length(15'd2);
        queue_byte(LF_BYTE);
        queue_byte(CR_BYTE);
        queue_byte(CR_BYTE);
        queue_byte(LF_BYTE);

        // receiver holds off while records keep coming
        set_record_length(15'd3);
        repeat (15)
            queue_record(3, 1'b1, 1'b1);
        holds_asked++;

        while (items_queued < RANDOM_ITEMS)
        begin
            if (items_queued > RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            pick = $urandom_range(0, 39);
            if (pick < 5)
            begin
                set_record_length(15'd0);
                repeat ($urandom_range(5, 40))
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else if (pick == 5)
            begin
                set_record_length(15'h7FFF);
                repeat ($urandom_range(5, 20))
                    queue_byte(text_byte());
            end
            else
            begin
                if (pick < 32)
                    len = $urandom_range(1, 8);
                else if (pick < 39)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(100, 300);
                set_record_length(15'(len));
                repeat ($urandom_range(1, 6))
                    queue_record(len, 1'b1, 1'b1);
                // sometimes the phase ends inside a record
                case ($urandom_range(0, 3))
                    0: queue_record($urandom_range(0, len), 1'b0, 1'b0);
                    1: queue_record(len, 1'b1, 1'b0);
                    default: ;
                endcase
            end
        end

        // last phase: one framing error, then bytes that must be dropped
        calm = 1'b1;
        len = $urandom_range(1, 4);
        set_record_length(15'(len));
        queue_record(len, 1'b1, 1'b1);
        if ($urandom_range(0, 1) == 0)
        begin
            do
                bad = 8'($urandom_range(0, 255));
            while (bad == CR_BYTE);
            queue_record(len, 1'b0, 1'b0);
        end
        else
        begin
            do
                bad = 8'($urandom_range(0, 255));
            while (bad == LF_BYTE);
            queue_record(len, 1'b1, 1'b0);
        end
        queue_byte(bad);
        queue_byte(CR_BYTE);
        queue_byte(LF_BYTE);
        repeat (8)
            queue_byte(8'($urandom_range(0, 255)));

        wait_quiescent();
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
